>>> sv/uhml_pkg.sv
// ----------------------------------------------------------------------------
// uhml_pkg: shared types and constants
// Mode codes, result actions and the job word passed from front to back.
// ----------------------------------------------------------------------------
package uhml_pkg;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_U_COUNT = 4'd1,
		M_U_ADDR  = 4'd2,
		M_U_DATA  = 4'd3,
		M_G_ADDR  = 4'd4,
		M_V_START = 4'd5,
		M_V_END   = 4'd6,
		M_V_WAIT  = 4'd7,
		M_ECHO    = 4'd8,
		M_E_WORD  = 4'd9
	} mode_t;

	localparam logic [1:0] ACT_TX    = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_JUMP  = 2'd3;

	// job kinds run by the back end
	typedef enum logic [2:0] {
		J_CHAR  = 3'd0,  // one character
		J_WRITE = 3'd1,  // byte write
		J_JUMP  = 3'd2,  // jump
		J_HEX2P = 3'd3,  // 2 hex digits then optional prompt
		J_VIEW  = 3'd4,  // optional 8-hex word, optional header, space, read
		J_HEXP  = 3'd5   // 8 hex digits then prompt
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  ch;
		logic [31:0] addr;
		logic [31:0] data;
		logic        flag_a;  // prompt after / header for view
		logic        flag_b;  // view: word printed first
	} job_t;

	localparam int unsigned QDEPTH = 4;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		hex_char = (d >= 4'ha) ? (8'd55 + {4'd0, d}) : (8'd48 + {4'd0, d});
	endfunction

endpackage

>>> sv/uhml_front.sv
// ----------------------------------------------------------------------------
// uhml_front: command parser
// Accepts words, runs the monitor state and issues at most one job per word.
// ----------------------------------------------------------------------------
module uhml_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  logic                  command,
	input  logic [7:0]            rx_char,
	input  logic [31:0]           read_data,
	output logic                  job_valid,
	input  logic                  job_stall,
	output uhml_pkg::job_t        job
);

	uhml_pkg::mode_t mode_q, mode_d;
	logic [3:0]  dc_q, dc_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  left_q, left_d;
	logic [31:0] cur_q, cur_d;
	logic [31:0] end_q, end_d;
	logic [1:0]  wol_q, wol_d;
	logic        has_job;
	uhml_pkg::job_t jd;

	logic [3:0]  nib;
	logic [31:0] acc_n;
	logic [3:0]  dc_n;
	logic [7:0]  sum_n;
	logic        done2, done8;
	logic        take;
	logic [32:0] cur4;

	assign stall = job_stall;
	assign take  = valid && !stall;

	always_comb begin
		nib   = (rx_char <= 8'd57) ? 4'(rx_char - 8'd48) : 4'(rx_char + 8'd9);
		acc_n = {acc_q[27:0], nib};
		dc_n  = dc_q + 4'd1;
		sum_n = dc_n[0] ? sum_q : sum_q + acc_n[7:0];
		done2 = dc_n >= 4'd2;
		done8 = dc_n >= 4'd8;
		cur4  = {1'b0, cur_q} + 33'd4;
	end

	always_comb begin
		mode_d = mode_q; dc_d = dc_q; acc_d = acc_q; sum_d = sum_q;
		left_d = left_q; cur_d = cur_q; end_d = end_q; wol_d = wol_q;
		has_job = 1'b0;
		jd = '0;
		if (mode_q == uhml_pkg::M_V_WAIT) begin
			if (command) begin
				has_job = 1'b1;
				cur_d = cur4[31:0];
				if (cur4[32] || !(cur4[31:0] < end_q)) begin
					jd.kind = uhml_pkg::J_HEXP;
					jd.data = read_data;
					mode_d = uhml_pkg::M_IDLE;
				end else begin
					jd.kind = uhml_pkg::J_VIEW;
					jd.data = read_data;
					jd.addr = cur4[31:0];
					jd.flag_b = 1'b1;
					jd.flag_a = (wol_q == 2'd0);
					wol_d = wol_q + 2'd1;
				end
			end
		end else if (!command) begin
			unique case (mode_q)
				uhml_pkg::M_U_COUNT, uhml_pkg::M_U_ADDR, uhml_pkg::M_U_DATA,
				uhml_pkg::M_G_ADDR, uhml_pkg::M_V_START, uhml_pkg::M_V_END,
				uhml_pkg::M_E_WORD: begin
					acc_d = acc_n; dc_d = dc_n; sum_d = sum_n;
					if ((mode_q == uhml_pkg::M_U_COUNT || mode_q == uhml_pkg::M_U_DATA)
						? done2 : done8) begin
						acc_d = '0; dc_d = '0;
						unique case (mode_q)
							uhml_pkg::M_U_COUNT: begin
								left_d = (acc_n[7:0] >= 8'd5) ? acc_n[7:0] - 8'd5 : 8'd0;
								mode_d = uhml_pkg::M_U_ADDR;
							end
							uhml_pkg::M_U_ADDR: begin
								cur_d = acc_n;
								if (left_q == 8'd0) begin
									has_job = 1'b1;
									jd.kind = uhml_pkg::J_HEX2P;
									jd.ch = ~sum_n; jd.flag_a = 1'b1;
									mode_d = uhml_pkg::M_IDLE;
								end else mode_d = uhml_pkg::M_U_DATA;
							end
							uhml_pkg::M_U_DATA: begin
								has_job = 1'b1;
								jd.kind = uhml_pkg::J_WRITE;
								jd.addr = cur_q; jd.ch = acc_n[7:0];
								cur_d = cur_q + 32'd1;
								left_d = left_q - 8'd1;
								if (left_q == 8'd1) begin
									jd.flag_a = 1'b1;
									jd.data = {24'd0, ~sum_n};
									mode_d = uhml_pkg::M_IDLE;
								end
							end
							uhml_pkg::M_G_ADDR: begin
								has_job = 1'b1;
								jd.kind = uhml_pkg::J_JUMP; jd.addr = acc_n;
								mode_d = uhml_pkg::M_IDLE;
							end
							uhml_pkg::M_V_START: begin
								cur_d = acc_n; mode_d = uhml_pkg::M_V_END;
							end
							uhml_pkg::M_V_END: begin
								end_d = acc_n;
								has_job = 1'b1;
								if (cur_q < acc_n) begin
									jd.kind = uhml_pkg::J_VIEW;
									jd.addr = cur_q; jd.flag_a = 1'b1;
									wol_d = 2'd1;
									mode_d = uhml_pkg::M_V_WAIT;
								end else begin
									jd.kind = uhml_pkg::J_CHAR; jd.ch = 8'd62;
									wol_d = 2'd0;
									mode_d = uhml_pkg::M_IDLE;
								end
							end
							default: begin
								has_job = 1'b1;
								jd.kind = uhml_pkg::J_HEX2P; jd.ch = sum_n;
							end
						endcase
					end
				end
				uhml_pkg::M_ECHO: begin
					has_job = 1'b1; jd.kind = uhml_pkg::J_CHAR; jd.ch = rx_char;
				end
				default: begin
					mode_d = uhml_pkg::M_IDLE; dc_d = '0; acc_d = '0;
					unique case (rx_char)
						8'd114: begin
							has_job = 1'b1; jd.kind = uhml_pkg::J_JUMP;
						end
						8'd117: begin sum_d = '0; mode_d = uhml_pkg::M_U_COUNT; end
						8'd103: mode_d = uhml_pkg::M_G_ADDR;
						8'd118: mode_d = uhml_pkg::M_V_START;
						8'd101: mode_d = uhml_pkg::M_ECHO;
						8'd69:  begin sum_d = '0; mode_d = uhml_pkg::M_E_WORD; end
						default: begin
							has_job = 1'b1; jd.kind = uhml_pkg::J_CHAR; jd.ch = 8'd62;
						end
					endcase
				end
			endcase
		end
		if (mode_q == uhml_pkg::M_V_WAIT && command && has_job &&
			jd.kind == uhml_pkg::J_VIEW) mode_d = uhml_pkg::M_V_WAIT;
	end

	assign job_valid = take && has_job;
	assign job = jd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= uhml_pkg::M_IDLE; dc_q <= '0; acc_q <= '0; sum_q <= '0;
			left_q <= '0; cur_q <= '0; end_q <= '0; wol_q <= '0;
		end else if (take) begin
			mode_q <= mode_d; dc_q <= dc_d; acc_q <= acc_d; sum_q <= sum_d;
			left_q <= left_d; cur_q <= cur_d; end_q <= end_d; wol_q <= wol_d;
		end
	end

endmodule

>>> sv/uhml_queue.sv
// ----------------------------------------------------------------------------
// uhml_queue: job queue
// Short register fifo between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module uhml_queue #(
	parameter int unsigned DEPTH = uhml_pkg::QDEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  uhml_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_stall,
	output uhml_pkg::job_t out_job
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	uhml_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign in_stall  = (cnt_q == (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_job   = mem_q[rp_q];
	assign push = in_valid && !in_stall;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

>>> sv/uhml_back.sv
// ----------------------------------------------------------------------------
// uhml_back: result sequencer
// Expands one job into its result words, one per cycle while the output is not stalled, registered output.
// ----------------------------------------------------------------------------
module uhml_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_stall,
	input  uhml_pkg::job_t job,
	output logic           valid,
	input  logic           stall,
	output logic [1:0]     action,
	output logic [7:0]     tx_char,
	output logic [31:0]    address,
	output logic [7:0]     write_byte,
	output logic           last
);

	// step codes within one job
	logic [4:0] step, nstep;
	logic [4:0] step_q;
	logic       busy_q;
	logic       out_free;
	logic [1:0] r_act;
	logic [7:0] r_ch;
	logic [31:0] r_addr;
	logic [7:0] r_wb;
	logic       r_last;
	logic [3:0] nib;

	assign out_free  = !valid || !stall;
	assign job_stall = !out_free || !r_last;
	assign step = busy_q ? step_q : 5'd0;

	// view layout: 0..7 word, 8..10 cr lf [, 11..18 addr, 19 ], 20 space, 21 read
	always_comb begin
		r_act = uhml_pkg::ACT_TX; r_ch = '0; r_addr = '0; r_wb = '0; r_last = 1'b0;
		nstep = step + 5'd1;
		nib = '0;
		case (job.kind)
			uhml_pkg::J_CHAR: begin r_ch = job.ch; r_last = 1'b1; end
			uhml_pkg::J_JUMP: begin
				r_act = uhml_pkg::ACT_JUMP; r_addr = job.addr; r_last = 1'b1;
			end
			uhml_pkg::J_WRITE: begin
				if (step == 5'd0) begin
					r_act = uhml_pkg::ACT_WRITE; r_addr = job.addr; r_wb = job.ch;
					r_last = !job.flag_a;
				end else if (step <= 5'd2) begin
					nib = (step == 5'd1) ? job.data[7:4] : job.data[3:0];
					r_ch = uhml_pkg::hex_char(nib);
				end else begin
					r_ch = 8'd62; r_last = 1'b1;
				end
			end
			uhml_pkg::J_HEX2P: begin
				if (step <= 5'd1) begin
					nib = (step == 5'd0) ? job.ch[7:4] : job.ch[3:0];
					r_ch = uhml_pkg::hex_char(nib);
					r_last = (step == 5'd1) && !job.flag_a;
				end else begin
					r_ch = 8'd62; r_last = 1'b1;
				end
			end
			uhml_pkg::J_HEXP: begin
				if (step <= 5'd7) begin
					nib = job.data[{3'd7 - step[2:0], 2'b00} +: 4];
					r_ch = uhml_pkg::hex_char(nib);
				end else begin
					r_ch = 8'd62; r_last = 1'b1;
				end
			end
			default: begin
				if (step <= 5'd7) begin
					nib = job.data[{3'd7 - step[2:0], 2'b00} +: 4];
					r_ch = uhml_pkg::hex_char(nib);
				end else if (step == 5'd8) r_ch = 8'd13;
				else if (step == 5'd9) r_ch = 8'd10;
				else if (step == 5'd10) r_ch = 8'd91;
				else if (step <= 5'd18) begin
					nib = job.addr[{3'd7 - 3'(step - 5'd11), 2'b00} +: 4];
					r_ch = uhml_pkg::hex_char(nib);
				end else if (step == 5'd19) r_ch = 8'd93;
				else if (step == 5'd20) r_ch = 8'd32;
				else begin
					r_act = uhml_pkg::ACT_READ; r_addr = job.addr; r_last = 1'b1;
				end
				// skip to the right next step
				if (step == 5'd7 || (!job.flag_b && step == 5'd0 && !busy_q))
					nstep = job.flag_a ? 5'd8 : 5'd20;
				if (!busy_q && !job.flag_b) begin
					r_ch = job.flag_a ? 8'd13 : 8'd32;
					r_act = uhml_pkg::ACT_TX; r_addr = '0; r_last = 1'b0;
					nstep = job.flag_a ? 5'd9 : 5'd21;
				end
			end
		endcase
	end

	// job register: the head job stays in the queue until its last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; step_q <= '0; valid <= 1'b0;
		end else if (out_free) begin
			valid <= job_valid;
			if (job_valid) begin
				busy_q <= !r_last;
				step_q <= nstep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && job_valid) begin
			action <= r_act; tx_char <= r_ch; address <= r_addr;
			write_byte <= r_wb; last <= r_last;
		end
	end

endmodule

>>> sv/uart_hex_monitor_loader_core.sv
// ----------------------------------------------------------------------------
// uart_hex_monitor_loader_core: serial hex boot monitor
// Parser front end, job queue and result sequencer.
// ----------------------------------------------------------------------------
// Each input word is parsed in the cycle it is accepted; a word that causes
// results leaves a job in a four-entry queue, and the sequencer sends that
// job's results one per cycle while the output is not stalled, from one (a
// character) to twenty-two (a view line header with a word). Input is taken
// back to back while the queue has room; sustained rate is the sequencer's.
module uart_hex_monitor_loader_core #(
	parameter int unsigned QDEPTH = uhml_pkg::QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rx_char,
	input  logic [31:0] read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [7:0]  tx_char,
	output logic [31:0] address,
	output logic [7:0]  write_byte,
	output logic        last
);

	logic           f_valid, f_stall, b_valid, b_stall, b_pop;
	uhml_pkg::job_t f_job, b_job;

	uhml_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.command(command), .rx_char(rx_char), .read_data(read_data),
		.job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	uhml_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_stall(f_stall),
		.in_job(f_job), .out_valid(b_valid), .out_stall(b_pop), .out_job(b_job)
	);

	// pop only when the sequencer takes the job's last word
	uhml_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(b_valid), .job_stall(b_stall),
		.job(b_job), .valid(out_valid), .stall(out_stall), .action(action),
		.tx_char(tx_char), .address(address), .write_byte(write_byte), .last(last)
	);

	assign b_pop = b_stall;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for uart_hex_monitor_loader_core
// Drives received characters and memory read words into the boot monitor,
// predicts every transmit, write, read request and jump in order, and compares
// each output word field by field. A short table of directed rows covers
// prompts, jumps, short and wrapping uploads and view ranges; random command
// sequences follow under changing idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic [1:0]  act;
		logic [7:0]  ch;
		logic [31:0] addr;
		logic [7:0]  wb;
		logic        last;
	} result_t;

	typedef struct {
		bit          cmd;
		string       text;
		logic [31:0] rd;
		bit          typed;
		int          n_typed;
		result_t     res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [7:0]  rx_char = 8'd0;
	logic [31:0] read_data = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  action;
	logic [7:0]  tx_char;
	logic [31:0] address;
	logic [7:0]  write_byte;
	logic        last;

	uart_hex_monitor_loader_core DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	uhml_pkg::mode_t p_mode;
	logic [3:0]  p_digits;
	logic [31:0] p_acc;
	logic [7:0]  p_sum;
	logic [7:0]  p_left;
	logic [31:0] p_cursor;
	logic [31:0] p_end;
	logic [1:0]  p_on_line;

	result_t due_results[$];
	int      n_added;
	int      mismatches = 0;
	int      out_words = 0;
	int      items_sent = 0;
	int      quiet_cycles = 0;
	int      gap_pct = 0;
	int      stall_pct = 0;
	int      hold_cycles = 0;
	bit      in_accept;

	function automatic void push_result(logic [1:0] a, logic [7:0] c, logic [31:0] ad,
			logic [7:0] w);
		result_t r;
		r.act = a; r.ch = c; r.addr = ad; r.wb = w; r.last = 1'b0;
		due_results.push_back(r);
		n_added++;
	endfunction

	function automatic void push_hex(int n, logic [31:0] v);
		logic [3:0] d;
		for (int i = n - 1; i >= 0; i--) begin
			d = v[4*i +: 4];
			push_result(uhml_pkg::ACT_TX, (d >= 4'ha) ? 8'h41 + d - 8'd10 : 8'h30 + d,
				32'd0, 8'd0);
		end
	endfunction

	function automatic bit take_digit(logic [7:0] c, int n, output logic [31:0] val);
		logic [3:0] nib;
		nib = (c <= 8'h39) ? 4'(c - 8'h30) : 4'(c + 8'd9);
		p_acc = {p_acc[27:0], nib};
		p_digits = p_digits + 4'd1;
		if (!p_digits[0])
			p_sum = p_sum + p_acc[7:0];
		val = p_acc;
		if (p_digits >= n) begin
			p_acc = 32'd0;
			p_digits = 4'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void prompt_to_idle();
		push_result(uhml_pkg::ACT_TX, 8'h3e, 32'd0, 8'd0);
		p_mode = uhml_pkg::M_IDLE;
	endfunction

	function automatic void upload_finish();
		push_hex(2, {24'd0, ~p_sum});
		prompt_to_idle();
	endfunction

	function automatic void view_advance();
		if (p_cursor < p_end) begin
			if (p_on_line == 2'd0) begin
				push_result(uhml_pkg::ACT_TX, 8'h0d, 32'd0, 8'd0);
				push_result(uhml_pkg::ACT_TX, 8'h0a, 32'd0, 8'd0);
				push_result(uhml_pkg::ACT_TX, 8'h5b, 32'd0, 8'd0);
				push_hex(8, p_cursor);
				push_result(uhml_pkg::ACT_TX, 8'h5d, 32'd0, 8'd0);
			end
			p_on_line = p_on_line + 2'd1;
			push_result(uhml_pkg::ACT_TX, 8'h20, 32'd0, 8'd0);
			push_result(uhml_pkg::ACT_READ, 8'd0, p_cursor, 8'd0);
			p_mode = uhml_pkg::M_V_WAIT;
		end else begin
			prompt_to_idle();
		end
	endfunction

	// returns the number of results this word causes
	function automatic int monitor_step(bit cmd, logic [7:0] c, logic [31:0] rd);
		logic [31:0] v;
		n_added = 0;
		if (p_mode == uhml_pkg::M_V_WAIT) begin
			if (cmd) begin
				push_hex(8, rd);
				if (p_cursor > 32'hffff_fffb) begin
					p_cursor = p_cursor + 32'd4;
					prompt_to_idle();
				end else begin
					p_cursor = p_cursor + 32'd4;
					view_advance();
				end
			end
		end else if (!cmd) begin
			case (p_mode)
				uhml_pkg::M_U_COUNT: if (take_digit(c, 2, v)) begin
					p_left = (v[7:0] >= 8'd5) ? v[7:0] - 8'd5 : 8'd0;
					p_mode = uhml_pkg::M_U_ADDR;
				end
				uhml_pkg::M_U_ADDR: if (take_digit(c, 8, v)) begin
					p_cursor = v;
					if (p_left == 8'd0) upload_finish();
					else p_mode = uhml_pkg::M_U_DATA;
				end
				uhml_pkg::M_U_DATA: if (take_digit(c, 2, v)) begin
					push_result(uhml_pkg::ACT_WRITE, 8'd0, p_cursor, v[7:0]);
					p_cursor = p_cursor + 32'd1;
					p_left = p_left - 8'd1;
					if (p_left == 8'd0) upload_finish();
				end
				uhml_pkg::M_G_ADDR: if (take_digit(c, 8, v)) begin
					push_result(uhml_pkg::ACT_JUMP, 8'd0, v, 8'd0);
					p_mode = uhml_pkg::M_IDLE;
				end
				uhml_pkg::M_V_START: if (take_digit(c, 8, v)) begin
					p_cursor = v;
					p_mode = uhml_pkg::M_V_END;
				end
				uhml_pkg::M_V_END: if (take_digit(c, 8, v)) begin
					p_end = v;
					p_on_line = 2'd0;
					view_advance();
				end
				uhml_pkg::M_ECHO: push_result(uhml_pkg::ACT_TX, c, 32'd0, 8'd0);
				uhml_pkg::M_E_WORD: if (take_digit(c, 8, v)) push_hex(2, {24'd0, p_sum});
				default: begin
					p_mode = uhml_pkg::M_IDLE;
					p_digits = 4'd0;
					p_acc = 32'd0;
					case (c)
						8'h72: push_result(uhml_pkg::ACT_JUMP, 8'd0, 32'd0, 8'd0);
						8'h75: begin p_sum = 8'd0; p_mode = uhml_pkg::M_U_COUNT; end
						8'h67: p_mode = uhml_pkg::M_G_ADDR;
						8'h76: p_mode = uhml_pkg::M_V_START;
						8'h65: p_mode = uhml_pkg::M_ECHO;
						8'h45: begin p_sum = 8'd0; p_mode = uhml_pkg::M_E_WORD; end
						default: prompt_to_idle();
					endcase
				end
			endcase
		end
		if (n_added > 0)
			due_results[$].last = 1'b1;
		return n_added;
	endfunction

	// one input word through the handshake, predicted at acceptance
	task automatic send_word(bit cmd, logic [7:0] c, logic [31:0] rd, output int n);
		int gap;
		if ($urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		rx_char <= c;
		read_data <= rd;
		do @(posedge clk); while (in_stall);
		if (!((cmd && p_mode != uhml_pkg::M_V_WAIT) || (!cmd && p_mode == uhml_pkg::M_V_WAIT)))
			items_sent++;
		n = monitor_step(cmd, c, rd);
	endtask

	task automatic send_text(string s);
		int n;
		for (int i = 0; i < s.len(); i++)
			send_word(1'b0, s[i], 32'd0, n);
	endtask

	function automatic string hex_text(logic [31:0] v, int n);
		string s, lc;
		logic [3:0] d;
		s = "";
		for (int i = n - 1; i >= 0; i--) begin
			d = v[4*i +: 4];
			if ($urandom_range(15) == 0)
				s = {s, string'(8'($urandom_range(255)))};
			else begin
				lc = $urandom_range(1) ? "0123456789abcdef" : "0123456789ABCDEF";
				s = {s, string'(lc[d])};
			end
		end
		return s;
	endfunction

	task automatic answer_reads();
		int n;
		while (p_mode == uhml_pkg::M_V_WAIT) begin
			if ($urandom_range(9) == 0)
				send_word(1'b0, 8'($urandom_range(255)), 32'd0, n);
			send_word(1'b1, 8'($urandom_range(255)), $urandom, n);
		end
	endtask

	// receiver
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// result checker and watchdog
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			in_accept = in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				out_words++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: act %0d ch %h addr %h wb %h last %b",
							action, tx_char, address, write_byte, last);
				end else begin
					e = due_results.pop_front();
					if (e.act !== action || e.ch !== tx_char || e.addr !== address ||
							e.wb !== write_byte || e.last !== last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d/%h/%h/%h/%b got %0d/%h/%h/%h/%b",
								e.act, e.ch, e.addr, e.wb, e.last,
								action, tx_char, address, write_byte, last);
					end
				end
			end
			if (in_accept || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 5000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		int n, pick, cnt, base;
		logic [31:0] a;
		string s;

		p_mode = uhml_pkg::M_IDLE; p_digits = 4'd0; p_acc = 32'd0; p_sum = 8'd0;
		p_left = 8'd0; p_cursor = 32'd0; p_end = 32'd0; p_on_line = 2'd0;

		rows.push_back('{0, "x", 0, 1, 1, '{uhml_pkg::ACT_TX, 8'h3e, 32'd0, 8'd0, 1'b1}});
		rows.push_back('{0, "r", 0, 1, 1, '{uhml_pkg::ACT_JUMP, 8'd0, 32'd0, 8'd0, 1'b1}});
		rows.push_back('{1, "", 32'hffff_ffff, 1, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{0, "u03FFFFFFFF", 0, 0, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{0, "u07FFFFFFFE00ff", 0, 0, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{0, "u06zZ~;0000\x80\xff", 0, 0, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{0, "g00000000", 0, 1, 1,
			'{uhml_pkg::ACT_JUMP, 8'd0, 32'd0, 8'd0, 1'b1}});
		rows.push_back('{0, "gFFFFFFFF", 0, 1, 1,
			'{uhml_pkg::ACT_JUMP, 8'd0, 32'hffff_ffff, 8'd0, 1'b1}});
		rows.push_back('{0, "v0000001000000010", 0, 1, 1,
			'{uhml_pkg::ACT_TX, 8'h3e, 32'd0, 8'd0, 1'b1}});
		rows.push_back('{0, "vFFFFFFF8FFFFFFFF", 0, 0, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{0, "Z", 0, 1, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{1, "", 32'hffff_ffff, 0, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{1, "", 32'h0000_0000, 0, 0, '{0, 0, 0, 0, 0}});
		rows.push_back('{0, "m", 0, 1, 1, '{uhml_pkg::ACT_TX, 8'h3e, 32'd0, 8'd0, 1'b1}});
		rows.push_back('{0, "v0000000000000014", 0, 0, 0, '{0, 0, 0, 0, 0}});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			r = rows[i];
			if (r.cmd)
				send_word(1'b1, 8'd0, r.rd, n);
			else begin
				send_text(r.text.substr(0, r.text.len() - 2));
				send_word(1'b0, r.text[r.text.len() - 1], 32'd0, n);
			end
			if (r.typed) begin
				repeat (n) void'(due_results.pop_back());
				if (r.n_typed > 0)
					due_results.push_back(r.res);
			end
		end
		answer_reads();

		cnt = 0;
		base = items_sent;
		while (items_sent < 170) begin
			case (((items_sent - base) / 13) % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 51; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 51; end
				default: begin gap_pct = 25; stall_pct = 25; end
			endcase
			if (cnt == 8)
				hold_cycles = 200;
			cnt++;
			pick = $urandom_range(9);
			a = $urandom_range(7) == 0 ? 32'hffff_fff0 + $urandom_range(15) : $urandom;
			case (pick)
				0: send_text("r");
				1: send_text({"g", hex_text(a, 8)});
				2, 3, 4: begin
					s = hex_text($urandom_range(9) == 0 ? $urandom_range(4) :
						$urandom_range(5, 12), 2);
					s = {"u", s, hex_text(a, 8)};
					for (int k = 0; k < 8; k++)
						s = {s, hex_text($urandom, 2)};
					send_text(s.substr(0, 10));
					while (p_mode == uhml_pkg::M_U_DATA)
						send_text(hex_text($urandom, 1));
				end
				5, 6, 7: begin
					s = {"v", hex_text(a, 8), hex_text(a + $urandom_range(0, 40), 8)};
					send_text(s);
					answer_reads();
				end
				8: send_word(1'b1, 8'd0, $urandom, n);
				default: begin
					do n = $urandom_range(255); while (n == 8'h65 || n == 8'h45);
					send_word(1'b0, 8'(n), 32'd0, n);
				end
			endcase
		end

		// echo and word-sum loops never end, so one of them closes the run
		gap_pct = 25; stall_pct = 25;
		if ($urandom_range(1)) begin
			send_text("e");
			repeat (12) send_word(1'b0, 8'($urandom_range(255)), 32'd0, n);
		end else begin
			send_text("E");
			repeat (3) send_text(hex_text($urandom, 8));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (due_results.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("%0d input words accepted, %0d output words checked", items_sent, out_words);
		$display("uploads, jumps, views with wrap, prompts, loop modes, idle and stall mixes");
		if (mismatches == 0 && due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
